// ----- rtl/arm_brf_pkg.sv -----
// Package for the banked ARM register file: transaction types, command codes,
// bank codes, mode encodings and the banking functions.
// No dependencies.
package arm_brf_pkg;

    localparam int unsigned NumPhys   = 36;
    localparam int unsigned PhysAw    = $clog2(NumPhys);
    localparam logic [31:0] CpsrReset = 32'h0000_01D3;

    typedef logic [PhysAw-1:0] t_phys_addr;

    typedef struct packed {
        logic [2:0]  command;
        logic [3:0]  reg_index;
        logic [31:0] write_value;
        logic [4:0]  new_mode;
        logic [4:0]  field_pos;
    } t_in_item;

    typedef struct packed {
        logic [31:0] read_value;
        logic        error;
    } t_out_item;

    localparam logic [2:0] CMD_REG_RD   = 3'd0;
    localparam logic [2:0] CMD_REG_WR   = 3'd1;
    localparam logic [2:0] CMD_MODE     = 3'd2;
    localparam logic [2:0] CMD_FIELD_RD = 3'd3;
    localparam logic [2:0] CMD_FIELD_WR = 3'd4;
    localparam logic [2:0] CMD_SPSR_RD  = 3'd5;
    localparam logic [2:0] CMD_SPSR_WR  = 3'd6;

    localparam logic [2:0] BANK_USR = 3'd0;
    localparam logic [2:0] BANK_FIQ = 3'd1;
    localparam logic [2:0] BANK_IRQ = 3'd2;
    localparam logic [2:0] BANK_SVC = 3'd3;
    localparam logic [2:0] BANK_ABT = 3'd4;
    localparam logic [2:0] BANK_UND = 3'd5;
    localparam logic [2:0] BANK_SYS = 3'd6;
    localparam logic [2:0] BANK_BAD = 3'd7;

    localparam logic [4:0] ENC_USR = 5'h10;
    localparam logic [4:0] ENC_FIQ = 5'h11;
    localparam logic [4:0] ENC_IRQ = 5'h12;
    localparam logic [4:0] ENC_SVC = 5'h13;
    localparam logic [4:0] ENC_ABT = 5'h17;
    localparam logic [4:0] ENC_UND = 5'h1B;
    localparam logic [4:0] ENC_SYS = 5'h1F;

    localparam logic [4:0] POS_MODE = 5'd0;
    localparam logic [4:0] POS_GE   = 5'd16;

    localparam logic [3:0] REG_R8  = 4'd8;
    localparam logic [3:0] REG_R13 = 4'd13;
    localparam logic [3:0] REG_R14 = 4'd14;

    localparam t_phys_addr BASE_FIQ  = t_phys_addr'(16);
    localparam t_phys_addr BASE_SVC  = t_phys_addr'(23);
    localparam t_phys_addr BASE_ABT  = t_phys_addr'(25);
    localparam t_phys_addr BASE_UND  = t_phys_addr'(27);
    localparam t_phys_addr BASE_IRQ  = t_phys_addr'(29);
    localparam t_phys_addr SPSR_FIQ  = t_phys_addr'(31);
    localparam t_phys_addr SPSR_SVC  = t_phys_addr'(32);
    localparam t_phys_addr SPSR_ABT  = t_phys_addr'(33);
    localparam t_phys_addr SPSR_UND  = t_phys_addr'(34);
    localparam t_phys_addr SPSR_IRQ  = t_phys_addr'(35);

    function automatic logic [2:0] bank_of_mode(input logic [4:0] mode);
        logic [2:0] bank;
        case (mode)
            ENC_USR: bank = BANK_USR;
            ENC_FIQ: bank = BANK_FIQ;
            ENC_IRQ: bank = BANK_IRQ;
            ENC_SVC: bank = BANK_SVC;
            ENC_ABT: bank = BANK_ABT;
            ENC_UND: bank = BANK_UND;
            ENC_SYS: bank = BANK_SYS;
            default: bank = BANK_BAD;
        endcase
        return bank;
    endfunction

    function automatic t_phys_addr phys_index(input logic [3:0] r, input logic [2:0] bank);
        t_phys_addr idx;
        t_phys_addr off;
        off = t_phys_addr'(r == REG_R14);
        idx = t_phys_addr'(r);
        if (bank == BANK_FIQ && r >= REG_R8 && r <= REG_R14) begin
            idx = BASE_FIQ + t_phys_addr'(r - REG_R8);
        end else if (r == REG_R13 || r == REG_R14) begin
            case (bank)
                BANK_SVC: idx = BASE_SVC + off;
                BANK_ABT: idx = BASE_ABT + off;
                BANK_UND: idx = BASE_UND + off;
                BANK_IRQ: idx = BASE_IRQ + off;
                default:  idx = t_phys_addr'(r);
            endcase
        end
        return idx;
    endfunction

    function automatic t_phys_addr spsr_index(input logic [2:0] bank);
        t_phys_addr idx;
        case (bank)
            BANK_FIQ: idx = SPSR_FIQ;
            BANK_SVC: idx = SPSR_SVC;
            BANK_ABT: idx = SPSR_ABT;
            BANK_UND: idx = SPSR_UND;
            BANK_IRQ: idx = SPSR_IRQ;
            default:  idx = SPSR_FIQ;
        endcase
        return idx;
    endfunction

    function automatic logic has_spsr(input logic [2:0] bank);
        return bank != BANK_USR && bank != BANK_SYS && bank != BANK_BAD;
    endfunction

    function automatic logic [31:0] field_mask(input logic [4:0] pos);
        logic [31:0] mask;
        if (pos == POS_MODE) begin
            mask = 32'h0000_001F;
        end else if (pos == POS_GE) begin
            mask = 32'h0000_000F;
        end else begin
            mask = 32'h0000_0001;
        end
        return mask;
    endfunction

endpackage

// ----- rtl/arm_brf_ram.sv -----
// Generic single-port RAM with registered read data.
// A read takes place when enabled without a write. No dependencies.
module arm_brf_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 36
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                o_rdata <= r_mem[i_addr];
            end
        end
    end

endmodule

// ----- rtl/arm_banked_register_file_top.sv -----
// Top level of the banked ARM register file with CPSR.
// Depends on arm_brf_pkg and arm_brf_ram.
//
// Usage: each input transaction on i_item carries one command: a register
// read or write in the current bank, a mode change, a CPSR field read or
// write, or an SPSR read or write. Each command yields exactly one output
// transaction on o_item with the value read and an error flag.
// A transaction is taken at a rising edge with i_valid high and o_stall low;
// an output transaction completes with o_valid high and i_stall low.
// An accepted transaction passes through the internal stage and then the
// output register; o_valid rises once it reaches the output register.
// One transaction can be accepted in every cycle while o_stall is low; the
// register state and the RAM port update at the acceptance edge, where the
// RAM also registers its read data.
// The physical registers sit in a 36-entry RAM with a written flag per entry,
// so an entry never written since reset reads as zero.
// Reset sets the CPSR to supervisor mode with A, I and F set, selects the
// supervisor bank and clears all written flags; no clearing pass is needed.
// When the receiver stalls, the output register holds its transaction and
// o_stall rises once the internal stage is also full.
module arm_banked_register_file_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  arm_brf_pkg::t_in_item i_item,
    output logic                  o_valid,
    input  logic                  i_stall,
    output arm_brf_pkg::t_out_item o_item
);

    import arm_brf_pkg::*;

    logic               in_acc;
    logic               s1_move;
    logic [2:0]         cmd;
    logic               is_mode_chg;
    logic [4:0]         mode_src;
    logic [2:0]         mode_bank;
    logic               mode_ok;
    logic               spsr_ok;
    logic               is_reg;
    logic               is_spsr;
    t_phys_addr         mem_addr;
    logic               mem_we;
    logic               mem_rd;
    logic [31:0]        mask;
    logic               err;
    logic [31:0]        field_val;
    logic [31:0]        ram_rdata;

    logic [31:0]        r_cpsr;
    logic [31:0]        n_cpsr;
    logic [2:0]         r_bank;
    logic [2:0]         n_bank;
    logic [NumPhys-1:0] r_seen;
    logic               r_s1_valid;
    logic               r_s1_from_mem;
    logic               r_s1_seen;
    logic [31:0]        r_s1_value;
    logic               r_s1_err;
    logic               r_out_valid;
    t_out_item          r_out_item;

    assign s1_move = !r_out_valid || !i_stall;
    assign o_stall = r_s1_valid && !s1_move;
    assign in_acc  = i_valid && !o_stall;

    always_comb begin
        cmd         = i_item.command;
        is_mode_chg = cmd == CMD_MODE || (cmd == CMD_FIELD_WR && i_item.field_pos == POS_MODE);
        mode_src    = (cmd == CMD_FIELD_WR) ? i_item.write_value[4:0] : i_item.new_mode;
        mode_bank   = bank_of_mode(mode_src);
        mode_ok     = mode_bank != BANK_BAD;
        spsr_ok     = has_spsr(r_bank);
        is_reg      = cmd == CMD_REG_RD || cmd == CMD_REG_WR;
        is_spsr     = cmd == CMD_SPSR_RD || cmd == CMD_SPSR_WR;
        mem_addr    = is_reg ? phys_index(i_item.reg_index, r_bank) : spsr_index(r_bank);
        mem_we      = cmd == CMD_REG_WR || (cmd == CMD_SPSR_WR && spsr_ok);
        mem_rd      = cmd == CMD_REG_RD || (cmd == CMD_SPSR_RD && spsr_ok);
        mask        = field_mask(i_item.field_pos);
        err         = (is_mode_chg && !mode_ok) || (is_spsr && !spsr_ok);
        field_val   = (cmd == CMD_FIELD_RD) ? ((r_cpsr >> i_item.field_pos) & mask) : 32'd0;

        n_cpsr = r_cpsr;
        n_bank = r_bank;
        if (in_acc) begin
            if (is_mode_chg) begin
                if (mode_ok) begin
                    n_cpsr = {r_cpsr[31:5], mode_src};
                    n_bank = mode_bank;
                end
            end else if (cmd == CMD_FIELD_WR) begin
                n_cpsr = (r_cpsr & ~(mask << i_item.field_pos))
                       | ((i_item.write_value & mask) << i_item.field_pos);
            end
        end
    end

    arm_brf_ram #(
        .WIDTH(32),
        .DEPTH(NumPhys)
    ) u_ram (
        .i_clk  (i_clk),
        .i_en   (in_acc && (mem_we || mem_rd)),
        .i_we   (mem_we),
        .i_addr (mem_addr),
        .i_wdata(i_item.write_value),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpsr      <= CpsrReset;
            r_bank      <= BANK_SVC;
            r_seen      <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cpsr <= n_cpsr;
            r_bank <= n_bank;
            if (in_acc && mem_we) begin
                r_seen[mem_addr] <= 1'b1;
            end
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_from_mem <= mem_rd;
            r_s1_seen     <= r_seen[mem_addr];
            r_s1_value    <= field_val;
            r_s1_err      <= err;
        end
        if (s1_move && r_s1_valid) begin
            r_out_item.error      <= r_s1_err;
            r_out_item.read_value <= r_s1_from_mem ? (r_s1_seen ? ram_rdata : 32'd0)
                                                   : r_s1_value;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out_item;

    // The bank select never holds the invalid code.
    a_bank_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bank != BANK_BAD)
        else $error("bank select holds the invalid code");

    // A failed command never returns data.
    a_error_reads_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.error |-> o_item.read_value == 32'd0)
        else $error("error transaction carries nonzero data");

    // A held internal stage is not lost while the output is stalled.
    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_move |=> r_s1_valid && o_valid)
        else $error("internal stage dropped during stall");

    // A register write marks its physical entry as written.
    a_write_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && mem_we |=> r_seen[$past(mem_addr)])
        else $error("written flag not set after write");

    // Backpressure to the sender only arises with both stages full.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_s1_valid && r_out_valid && i_stall)
        else $error("stall raised with free space");

endmodule

// ----- dv/arm_brf_result_checker.sv -----
// Result checker for the banked ARM register file. It watches both channels,
// keeps its own banked register, CPSR and SPSR state to predict each response,
// and compares responses in order. Depends on arm_brf_pkg.
module arm_brf_result_checker (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_stall,
    input  arm_brf_pkg::t_in_item  i_in_item,
    input  logic                   i_out_valid,
    input  logic                   i_out_stall,
    input  arm_brf_pkg::t_out_item i_out_item,
    output int                     o_mismatches,
    output int                     o_pending
);

    import arm_brf_pkg::*;

    logic [31:0] regs [NumPhys];
    logic [31:0] cpsr;
    logic [2:0]  bank;
    t_out_item   expected_reads [$];

    function automatic logic [2:0] bank_for(input logic [4:0] mode);
        logic [2:0] b;
        case (mode)
            ENC_USR: b = BANK_USR;
            ENC_FIQ: b = BANK_FIQ;
            ENC_IRQ: b = BANK_IRQ;
            ENC_SVC: b = BANK_SVC;
            ENC_ABT: b = BANK_ABT;
            ENC_UND: b = BANK_UND;
            ENC_SYS: b = BANK_SYS;
            default: b = BANK_BAD;
        endcase
        return b;
    endfunction

    function automatic int slot_of(input logic [3:0] r);
        int off;
        int slot;
        off = (r == REG_R14) ? 1 : 0;
        slot = int'(r);
        if (bank == BANK_FIQ && r >= REG_R8 && r <= REG_R14) begin
            slot = int'(BASE_FIQ) + int'(r) - int'(REG_R8);
        end else if (r == REG_R13 || r == REG_R14) begin
            case (bank)
                BANK_SVC: slot = int'(BASE_SVC) + off;
                BANK_ABT: slot = int'(BASE_ABT) + off;
                BANK_UND: slot = int'(BASE_UND) + off;
                BANK_IRQ: slot = int'(BASE_IRQ) + off;
                default:  slot = int'(r);
            endcase
        end
        return slot;
    endfunction

    // User and system mode have no SPSR; that case yields -1.
    function automatic int spsr_slot();
        int slot;
        case (bank)
            BANK_FIQ: slot = int'(SPSR_FIQ);
            BANK_SVC: slot = int'(SPSR_SVC);
            BANK_ABT: slot = int'(SPSR_ABT);
            BANK_UND: slot = int'(SPSR_UND);
            BANK_IRQ: slot = int'(SPSR_IRQ);
            default:  slot = -1;
        endcase
        return slot;
    endfunction

    // An invalid encoding leaves the bank and the CPSR untouched.
    function automatic logic switch_mode(input logic [4:0] mode);
        logic [2:0] b;
        b = bank_for(mode);
        if (b == BANK_BAD) begin
            return 1'b0;
        end
        bank = b;
        cpsr = {cpsr[31:5], mode};
        return 1'b1;
    endfunction

    function automatic t_out_item predict_access(input t_in_item it);
        t_out_item   res;
        logic [31:0] mask;
        int          sp;
        res = '0;
        sp = spsr_slot();
        if (it.field_pos == POS_MODE) begin
            mask = 32'h0000_001F;
        end else if (it.field_pos == POS_GE) begin
            mask = 32'h0000_000F;
        end else begin
            mask = 32'h0000_0001;
        end
        case (it.command)
            CMD_REG_RD: begin
                res.read_value = regs[slot_of(it.reg_index)];
            end
            CMD_REG_WR: begin
                regs[slot_of(it.reg_index)] = it.write_value;
            end
            CMD_MODE: begin
                res.error = !switch_mode(it.new_mode);
            end
            CMD_FIELD_RD: begin
                res.read_value = (cpsr >> it.field_pos) & mask;
            end
            CMD_FIELD_WR: begin
                if (it.field_pos == POS_MODE) begin
                    res.error = !switch_mode(it.write_value[4:0]);
                end else begin
                    cpsr = (cpsr & ~(mask << it.field_pos))
                         | ((it.write_value & mask) << it.field_pos);
                end
            end
            CMD_SPSR_RD: begin
                if (sp < 0) begin
                    res.error = 1'b1;
                end else begin
                    res.read_value = regs[sp];
                end
            end
            CMD_SPSR_WR: begin
                if (sp < 0) begin
                    res.error = 1'b1;
                end else begin
                    regs[sp] = it.write_value;
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            for (int i = 0; i < NumPhys; i++) begin
                regs[i] = '0;
            end
            cpsr = CpsrReset;
            bank = BANK_SVC;
            expected_reads.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_reads.size() == 0) begin
                    o_mismatches++;
                    if (o_mismatches <= 10) begin
                        $display("%0t: unexpected response read_value=%h error=%b",
                                 $realtime, i_out_item.read_value, i_out_item.error);
                    end
                end else begin
                    want = expected_reads.pop_front();
                    if (want.read_value !== i_out_item.read_value
                            || want.error !== i_out_item.error) begin
                        o_mismatches++;
                        if (o_mismatches <= 10) begin
                            $display("%0t: expected %h error %b, got %h error %b",
                                     $realtime, want.read_value, want.error,
                                     i_out_item.read_value, i_out_item.error);
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_reads.push_back(predict_access(i_in_item));
            end
        end
        o_pending = expected_reads.size();
    end

endmodule

// ----- dv/arm_banked_register_file_top_test.sv -----
// Testbench top for the banked ARM register file: clock, reset, directed and
// random command traffic with random idling on both channels, and the verdict.
// Depends on arm_brf_pkg, arm_banked_register_file_top and arm_brf_result_checker.
module arm_banked_register_file_top_test;
    import arm_brf_pkg::*;

    localparam logic [2:0] CMD_UNUSED = 3'd7;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;
    int        mismatches;
    int        pending;
    bit        calm = 1'b0;
    int        stall_left = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    arm_banked_register_file_top u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (in_valid),
        .o_stall (in_stall),
        .i_item  (in_item),
        .o_valid (out_valid),
        .i_stall (out_stall),
        .o_item  (out_item)
    );

    arm_brf_result_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_item   (out_item),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always @(posedge clk) begin
        int roll;
        if (calm) begin
            out_stall <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            stall_left--;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 55) begin
                out_stall <= 1'b0;
                stall_left = $urandom_range(0, 5);
            end else if (roll < 90) begin
                out_stall <= 1'b1;
                stall_left = $urandom_range(0, 2);
            end else begin
                out_stall <= 1'b1;
                stall_left = $urandom_range(7, 29);
            end
        end
    end

    task automatic send_access(input t_in_item it);
        int roll;
        int gap;
        roll = $urandom_range(0, 99);
        if (calm || roll < 60) begin
            gap = 0;
        end else if (roll < 92) begin
            gap = $urandom_range(1, 3);
        end else begin
            gap = $urandom_range(8, 30);
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic issue(input logic [2:0] cmd, input logic [3:0] idx,
                         input logic [31:0] val, input logic [4:0] mode,
                         input logic [4:0] pos);
        t_in_item it;
        it.command = cmd;
        it.reg_index = idx;
        it.write_value = val;
        it.new_mode = mode;
        it.field_pos = pos;
        send_access(it);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    function automatic logic [4:0] pick_mode();
        logic [4:0] mode;
        case ($urandom_range(0, 6))
            0:       mode = ENC_USR;
            1:       mode = ENC_FIQ;
            2:       mode = ENC_IRQ;
            3:       mode = ENC_SVC;
            4:       mode = ENC_ABT;
            5:       mode = ENC_UND;
            default: mode = ENC_SYS;
        endcase
        return mode;
    endfunction

    function automatic t_in_item random_access();
        t_in_item it;
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 22) begin
            it.command = CMD_REG_RD;
        end else if (roll < 42) begin
            it.command = CMD_REG_WR;
        end else if (roll < 54) begin
            it.command = CMD_MODE;
        end else if (roll < 64) begin
            it.command = CMD_FIELD_RD;
        end else if (roll < 76) begin
            it.command = CMD_FIELD_WR;
        end else if (roll < 85) begin
            it.command = CMD_SPSR_RD;
        end else if (roll < 95) begin
            it.command = CMD_SPSR_WR;
        end else begin
            it.command = CMD_UNUSED;
        end
        it.reg_index = 4'($urandom_range(0, 15));
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
            it.write_value = 32'hFFFF_FFFF;
        end else if (roll < 15) begin
            it.write_value = '0;
        end else begin
            it.write_value = $urandom;
        end
        it.new_mode = ($urandom_range(0, 99) < 85) ? pick_mode()
                                                   : 5'($urandom_range(0, 31));
        roll = $urandom_range(0, 99);
        if (roll < 25) begin
            it.field_pos = POS_MODE;
        end else if (roll < 40) begin
            it.field_pos = POS_GE;
        end else begin
            it.field_pos = 5'($urandom_range(0, 31));
        end
        if (it.command == CMD_FIELD_WR && it.field_pos == POS_MODE
                && $urandom_range(0, 99) < 85) begin
            it.write_value[4:0] = pick_mode();
        end
        return it;
    endfunction

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        issue(CMD_REG_RD,   REG_R13, '0,            '0,      '0);
        issue(CMD_FIELD_RD, '0,      '0,            '0,      POS_MODE);
        issue(CMD_FIELD_RD, '0,      '0,            '0,      POS_GE);
        issue(CMD_FIELD_RD, '0,      '0,            '0,      5'd31);
        issue(CMD_REG_WR,   4'd0,    32'hFFFF_FFFF, '0,      '0);
        issue(CMD_REG_WR,   4'd15,   32'h8000_0001, '0,      '0);
        issue(CMD_REG_WR,   REG_R14, 32'h0000_1234, '0,      '0);
        issue(CMD_REG_RD,   4'd0,    '0,            '0,      '0);
        issue(CMD_SPSR_WR,  '0,      32'hA5A5_5A5A, '0,      '0);
        issue(CMD_SPSR_RD,  '0,      '0,            '0,      '0);
        issue(CMD_MODE,     '0,      '0,            5'h00,   '0);
        issue(CMD_MODE,     '0,      '0,            ENC_FIQ, '0);
        issue(CMD_REG_WR,   REG_R8,  32'h1234_5678, '0,      '0);
        issue(CMD_REG_RD,   REG_R14, '0,            '0,      '0);
        issue(CMD_MODE,     '0,      '0,            ENC_USR, '0);
        issue(CMD_REG_RD,   REG_R8,  '0,            '0,      '0);
        issue(CMD_SPSR_RD,  '0,      '0,            '0,      '0);
        issue(CMD_SPSR_WR,  '0,      32'hFFFF_FFFF, '0,      '0);
        issue(CMD_FIELD_WR, '0,      32'hFFFF_FFFF, '0,      POS_GE);
        issue(CMD_FIELD_WR, '0,      32'hFFFF_FFFB, '0,      POS_MODE);
        issue(CMD_FIELD_WR, '0,      32'h0000_001E, '0,      POS_MODE);
        issue(CMD_FIELD_WR, '0,      32'h0000_0001, '0,      5'd31);
        issue(CMD_UNUSED,   4'hF,    32'hFFFF_FFFF, 5'h1F,   5'h1F);
        issue(CMD_MODE,     '0,      '0,            ENC_SYS, '0);
        issue(CMD_SPSR_RD,  '0,      '0,            '0,      '0);
        wait_drained();

        for (int n = 0; n < 900; n++) begin
            if (n % 150 == 0) begin
                calm = ($urandom_range(0, 2) == 0);
            end
            if (n == 450) begin
                wait_drained();
            end
            send_access(random_access());
        end
        wait_drained();
        repeat (8) @(posedge clk);

        if (mismatches == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
